/* rtl/bpc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the barometric pressure compensation pipeline.
// Used by the channel interfaces and by every module of the block.
package bpc_pkg;

	localparam int unsigned RAW_W       = 20;
	localparam int unsigned QUOT_W      = 64;
	localparam int unsigned DENOM_W     = 31;
	localparam int unsigned DIV_STEPS   = 4;
	localparam int unsigned DIV_STAGES  = QUOT_W / DIV_STEPS;
	localparam int unsigned FRONT_DEPTH = 8;
	localparam int unsigned BACK_DEPTH  = 6;
	localparam int unsigned PIPE_DEPTH  = FRONT_DEPTH + DIV_STAGES + 1 + BACK_DEPTH + 1;

	localparam int TFINE_OFFSET = 128000;
	localparam int PR_BASE      = 1048576;
	localparam int DIV_SCALE    = 3125;
	localparam int CUTOFF_RESET = 18700;

	localparam int unsigned REG_INDEX_W = 3;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_TEMP_COEFFS,
		REG_PRESS_A,
		REG_PRESS_B,
		REG_PRESS_NINE,
		REG_CUTOFF
	} reg_index_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw_temperature;
		logic [RAW_W-1:0] raw_pressure;
	} sample_t;

	typedef struct packed {
		logic [31:0] pressure_q24_8;
		logic        below_cutoff;
		logic        divide_fault;
	} result_t;

	typedef struct packed {
		logic        [15:0] t1;
		logic signed [15:0] t2;
		logic signed [15:0] t3;
		logic        [15:0] p1;
		logic signed [15:0] p2;
		logic signed [15:0] p3;
		logic signed [15:0] p4;
		logic signed [15:0] p5;
		logic signed [15:0] p6;
		logic signed [15:0] p7;
		logic signed [15:0] p8;
		logic signed [15:0] p9;
	} coef_t;

	typedef struct packed {
		logic [QUOT_W-1:0]  numer;
		logic [DENOM_W-1:0] denom;
	} div_req_t;

	typedef struct packed {
		logic [QUOT_W-1:0] quot;
		logic              neg;
		logic              fault;
	} div_rsp_t;

	typedef struct packed {
		logic [31:0] press;
		logic        fault;
	} press_rsp_t;

endpackage

/* rtl/bpc_if.sv */
`timescale 1ns / 1ps
// Valid/ready channel interfaces for raw samples and compensated results.
// Payload types come from bpc_pkg.
interface bpc_sample_if;
	import bpc_pkg::*;
	logic    valid;
	logic    ready;
	sample_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bpc_result_if;
	import bpc_pkg::*;
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/baro_pressure_compensation.sv */
`timescale 1ns / 1ps
// Barometric pressure compensation, top level: configuration registers, front, divider,
// back and the output register. One request is accepted every cycle unless the output is
// back-pressured, set by the fully pipelined divider that retires four quotient bits per
// stage. Ready follows the per-stage valid bits, so bubbles are filled while a result
// waits. Reset clears all valid bits and loads the register reset values (cutoff 18700 Pa,
// coefficients zero).
module baro_pressure_compensation (
	input  logic                                 clk,
	input  logic                                 arst_n,
	bpc_sample_if.sink                           sample,
	bpc_result_if.source                         result,
	input  logic                                 cfg_we,
	input  logic [bpc_pkg::REG_INDEX_W-1:0]      cfg_index,
	input  logic [63:0]                          cfg_wdata
);
	import bpc_pkg::*;

	localparam int unsigned CNT_W = $clog2(PIPE_DEPTH + 1);

	logic [47:0] temp_coeffs_q;
	logic [63:0] press_a_q;
	logic [63:0] press_b_q;
	logic [15:0] press_nine_q;
	logic [16:0] cutoff_q;

	coef_t coef;

	logic       front_valid, front_ready;
	div_req_t   front_data;
	logic       div_valid, div_ready;
	div_rsp_t   div_data;
	logic       back_valid, back_ready;
	press_rsp_t back_data;

	logic       res_vld_q;
	result_t    res_q;
	logic [CNT_W-1:0] inflight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_coeffs_q <= '0;
			press_a_q     <= '0;
			press_b_q     <= '0;
			press_nine_q  <= '0;
			cutoff_q      <= 17'(CUTOFF_RESET);
		end else if (cfg_we) begin
			unique case (reg_index_t'(cfg_index))
				REG_TEMP_COEFFS: temp_coeffs_q <= cfg_wdata[47:0];
				REG_PRESS_A:     press_a_q     <= cfg_wdata;
				REG_PRESS_B:     press_b_q     <= cfg_wdata;
				REG_PRESS_NINE:  press_nine_q  <= cfg_wdata[15:0];
				REG_CUTOFF:      cutoff_q      <= cfg_wdata[16:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		coef.t1 = temp_coeffs_q[15:0];
		coef.t2 = temp_coeffs_q[31:16];
		coef.t3 = temp_coeffs_q[47:32];
		coef.p1 = press_a_q[15:0];
		coef.p2 = press_a_q[31:16];
		coef.p3 = press_a_q[47:32];
		coef.p4 = press_a_q[63:48];
		coef.p5 = press_b_q[15:0];
		coef.p6 = press_b_q[31:16];
		coef.p7 = press_b_q[47:32];
		coef.p8 = press_b_q[63:48];
		coef.p9 = press_nine_q;
	end

	bpc_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (coef),
		.up_valid (sample.valid),
		.up_ready (sample.ready),
		.up_data  (sample.data),
		.dn_valid (front_valid),
		.dn_ready (front_ready),
		.dn_data  (front_data)
	);

	bpc_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (front_valid),
		.up_ready (front_ready),
		.up_data  (front_data),
		.dn_valid (div_valid),
		.dn_ready (div_ready),
		.dn_data  (div_data)
	);

	bpc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.coef     (coef),
		.up_valid (div_valid),
		.up_ready (div_ready),
		.up_data  (div_data),
		.dn_valid (back_valid),
		.dn_ready (back_ready),
		.dn_data  (back_data)
	);

	assign back_ready = !res_vld_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (back_ready) begin
			res_vld_q <= back_valid;
		end
	end

	// A zero divisor forces the pressure to zero and suppresses the cutoff flag.
	always_ff @(posedge clk) begin
		if (back_ready) begin
			res_q.pressure_q24_8 <= back_data.fault ? 32'd0 : back_data.press;
			res_q.below_cutoff   <= !back_data.fault && (back_data.press[31:8] < {7'd0, cutoff_q});
			res_q.divide_fault   <= back_data.fault;
		end
	end

	assign result.valid = res_vld_q;
	assign result.data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
		end else begin
			inflight_q <= inflight_q + CNT_W'(sample.valid && sample.ready)
			                         - CNT_W'(result.valid && result.ready);
		end
	end

	a_ready_only_on_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (result.valid && !result.ready))
		else $error("input stalled without output backpressure");

	a_inflight_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= CNT_W'(PIPE_DEPTH))
		else $error("more requests in flight than pipeline stages");

	a_result_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (inflight_q != '0))
		else $error("result presented with no request in flight");

endmodule

/* rtl/bpc_front.sv */
`timescale 1ns / 1ps
// Front pipeline: fine temperature, the pressure polynomial terms, divisor and dividend.
// Eight register stages; depends on bpc_pkg.
module bpc_front (
	input  logic             clk,
	input  logic             arst_n,
	input  bpc_pkg::coef_t   coef,
	input  logic             up_valid,
	output logic             up_ready,
	input  bpc_pkg::sample_t up_data,
	output logic             dn_valid,
	input  logic             dn_ready,
	output bpc_pkg::div_req_t dn_data
);
	import bpc_pkg::*;

	logic [FRONT_DEPTH-1:0] vld_q;
	logic [FRONT_DEPTH:0]   adv;

	logic        [RAW_W-1:0] rp_s1, rp_s2, rp_s3, rp_s4, rp_s5, rp_s6;
	logic        [31:0] lin_s1, bsq_s1, quad_s2;
	logic signed [20:0] lin_s2;
	logic signed [23:0] v1_s3;
	logic signed [47:0] sq_s4;
	logic signed [39:0] m5_s4, m2_s4, m5_s5, m2_s5;
	logic signed [63:0] m6_s5, m3_s5, v2_s6, x_s6;
	logic        [63:0] dprod_s7, num0_s7, numer_s8;
	logic        [DENOM_W-1:0] denom_s8;

	logic signed [17:0] diff_a;
	logic signed [16:0] diff_b;
	logic signed [33:0] lin_prod, bsq_prod;
	logic signed [19:0] bsq_sh;
	logic signed [35:0] quad_prod;
	logic signed [17:0] quad;
	logic signed [21:0] t_fine;
	logic        [20:0] pr;

	always_comb begin
		adv[FRONT_DEPTH] = dn_ready;
		for (int k = FRONT_DEPTH - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign up_ready = adv[0];
	assign dn_valid = vld_q[FRONT_DEPTH-1];
	assign dn_data  = '{numer: numer_s8, denom: denom_s8};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= up_valid;
			end
			for (int k = 1; k < FRONT_DEPTH; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_comb begin
		diff_a = $signed({1'b0, up_data.raw_temperature[19:3]}) - $signed({1'b0, coef.t1, 1'b0});
		diff_b = $signed({1'b0, up_data.raw_temperature[19:4]}) - $signed({1'b0, coef.t1});
		lin_prod = 34'(diff_a) * 34'($signed(coef.t2));
		bsq_prod = 34'(diff_b) * 34'(diff_b);
		bsq_sh = $signed(bsq_s1[31:12]);
		quad_prod = 36'(bsq_sh) * 36'($signed(coef.t3));
		quad = $signed(quad_s2[31:14]);
		// The linear and quadratic terms are small enough that the sum never wraps.
		t_fine = 22'(lin_s2) + 22'(quad);
		pr = 21'(PR_BASE) - {1'b0, rp_s6};
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			lin_s1 <= lin_prod[31:0];
			bsq_s1 <= bsq_prod[31:0];
			rp_s1  <= up_data.raw_pressure;
		end
		if (adv[1]) begin
			lin_s2  <= $signed(lin_s1[31:11]);
			quad_s2 <= quad_prod[31:0];
			rp_s2   <= rp_s1;
		end
		if (adv[2]) begin
			v1_s3 <= 24'(t_fine) - 24'(TFINE_OFFSET);
			rp_s3 <= rp_s2;
		end
		if (adv[3]) begin
			sq_s4 <= 48'(v1_s3) * 48'(v1_s3);
			m5_s4 <= 40'(v1_s3) * 40'($signed(coef.p5));
			m2_s4 <= 40'(v1_s3) * 40'($signed(coef.p2));
			rp_s4 <= rp_s3;
		end
		if (adv[4]) begin
			m6_s5 <= 64'(sq_s4) * 64'($signed(coef.p6));
			m3_s5 <= 64'(sq_s4) * 64'($signed(coef.p3));
			m5_s5 <= m5_s4;
			m2_s5 <= m2_s4;
			rp_s5 <= rp_s4;
		end
		if (adv[5]) begin
			v2_s6 <= m6_s5 + (64'(m5_s5) <<< 17) + (64'($signed(coef.p4)) <<< 35);
			x_s6  <= (64'(1) <<< 47) + (m3_s5 >>> 8) + (64'(m2_s5) <<< 12);
			rp_s6 <= rp_s5;
		end
		if (adv[6]) begin
			dprod_s7 <= x_s6 * {48'd0, coef.p1};
			num0_s7  <= ({43'd0, pr} << 31) - v2_s6;
		end
		if (adv[7]) begin
			denom_s8 <= dprod_s7[63:33];
			numer_s8 <= num0_s7 * 64'(DIV_SCALE);
		end
	end

endmodule

/* rtl/bpc_div.sv */
`timescale 1ns / 1ps
// Pipelined signed 64-bit by 31-bit divider, restoring, DIV_STEPS quotient bits per stage.
// One sign/magnitude entry stage then DIV_STAGES iteration stages; depends on bpc_pkg.
module bpc_div (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               up_valid,
	output logic               up_ready,
	input  bpc_pkg::div_req_t  up_data,
	output logic               dn_valid,
	input  logic               dn_ready,
	output bpc_pkg::div_rsp_t  dn_data
);
	import bpc_pkg::*;

	localparam int unsigned NSTG = DIV_STAGES + 1;

	typedef struct packed {
		logic [QUOT_W-1:0] acc;
		logic [31:0]       rem;
	} div_state_t;

	// Shift the dividend out of the top of acc while quotient bits enter at the bottom.
	function automatic div_state_t div_step(div_state_t st, logic [DENOM_W-1:0] md);
		div_state_t  nx;
		logic [31:0] trial;
		nx = st;
		for (int j = 0; j < DIV_STEPS; j++) begin
			trial  = {nx.rem[30:0], nx.acc[QUOT_W-1]};
			nx.acc = {nx.acc[QUOT_W-2:0], 1'b0};
			if (trial >= {1'b0, md}) begin
				nx.rem    = trial - {1'b0, md};
				nx.acc[0] = 1'b1;
			end else begin
				nx.rem = trial;
			end
		end
		return nx;
	endfunction

	logic [NSTG-1:0] vld_q;
	logic [NSTG:0]   adv;

	logic [QUOT_W-1:0]  acc_q   [NSTG];
	logic [31:0]        rem_q   [NSTG];
	logic [DENOM_W-1:0] md_q    [NSTG];
	logic               neg_q   [NSTG];
	logic               fault_q [NSTG];
	div_state_t         step_d  [DIV_STAGES];

	always_comb begin
		adv[NSTG] = dn_ready;
		for (int k = NSTG - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	always_comb begin
		for (int k = 0; k < DIV_STAGES; k++) begin
			step_d[k] = div_step(div_state_t'{acc: acc_q[k], rem: rem_q[k]}, md_q[k]);
		end
	end

	assign up_ready = adv[0];
	assign dn_valid = vld_q[NSTG-1];
	assign dn_data  = '{quot: acc_q[NSTG-1], neg: neg_q[NSTG-1], fault: fault_q[NSTG-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= up_valid;
			end
			for (int k = 1; k < NSTG; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			acc_q[0]   <= up_data.numer[QUOT_W-1] ? (QUOT_W'(0) - up_data.numer) : up_data.numer;
			rem_q[0]   <= '0;
			md_q[0]    <= up_data.denom[DENOM_W-1] ? (DENOM_W'(0) - up_data.denom)
			                                      : up_data.denom;
			neg_q[0]   <= up_data.numer[QUOT_W-1] ^ up_data.denom[DENOM_W-1];
			fault_q[0] <= (up_data.denom == '0);
		end
		for (int k = 0; k < DIV_STAGES; k++) begin
			if (adv[k+1]) begin
				acc_q[k+1]   <= step_d[k].acc;
				rem_q[k+1]   <= step_d[k].rem;
				md_q[k+1]    <= md_q[k];
				neg_q[k+1]   <= neg_q[k];
				fault_q[k+1] <= fault_q[k];
			end
		end
	end

endmodule

/* rtl/bpc_back.sv */
`timescale 1ns / 1ps
// Back pipeline: signs the quotient and applies the P7, P8 and P9 correction terms.
// Six register stages; the 64-bit square term is split into 32-bit partial products.
module bpc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  bpc_pkg::coef_t      coef,
	input  logic                up_valid,
	output logic                up_ready,
	input  bpc_pkg::div_rsp_t   up_data,
	output logic                dn_valid,
	input  logic                dn_ready,
	output bpc_pkg::press_rsp_t dn_data
);
	import bpc_pkg::*;

	logic [BACK_DEPTH-1:0] vld_q;
	logic [BACK_DEPTH:0]   adv;

	logic signed [63:0] q_s1, q_s2, q_s3, q_s4;
	logic signed [63:0] m9a_s2, c8p_s2, c8_s3, c8_s4, sum_s5;
	logic        [63:0] pll_s3, c9p_s4;
	logic        [31:0] xa_s3, xb_s3, press_s6;
	logic               fault_s1, fault_s2, fault_s3, fault_s4, fault_s5, fault_s6;

	logic signed [63:0] qs_b2, qs_b3;

	always_comb begin
		adv[BACK_DEPTH] = dn_ready;
		for (int k = BACK_DEPTH - 1; k >= 0; k--) begin
			adv[k] = !vld_q[k] || adv[k+1];
		end
	end

	assign up_ready = adv[0];
	assign dn_valid = vld_q[BACK_DEPTH-1];
	assign dn_data  = '{press: press_s6, fault: fault_s6};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (adv[0]) begin
				vld_q[0] <= up_valid;
			end
			for (int k = 1; k < BACK_DEPTH; k++) begin
				if (adv[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	assign qs_b2 = q_s1 >>> 13;
	assign qs_b3 = q_s2 >>> 13;

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			q_s1     <= up_data.neg ? $signed(64'd0 - up_data.quot) : $signed(up_data.quot);
			fault_s1 <= up_data.fault;
		end
		if (adv[1]) begin
			m9a_s2   <= 64'($signed(coef.p9)) * qs_b2;
			c8p_s2   <= 64'($signed(coef.p8)) * q_s1;
			q_s2     <= q_s1;
			fault_s2 <= fault_s1;
		end
		if (adv[2]) begin
			// Only the low 64 bits of the square term are kept, so the high-by-high
			// partial product drops out entirely.
			pll_s3   <= {32'd0, m9a_s2[31:0]} * {32'd0, qs_b3[31:0]};
			xa_s3    <= m9a_s2[31:0] * qs_b3[63:32];
			xb_s3    <= m9a_s2[63:32] * qs_b3[31:0];
			c8_s3    <= c8p_s2 >>> 19;
			q_s3     <= q_s2;
			fault_s3 <= fault_s2;
		end
		if (adv[3]) begin
			c9p_s4   <= pll_s3 + {xa_s3 + xb_s3, 32'd0};
			c8_s4    <= c8_s3;
			q_s4     <= q_s3;
			fault_s4 <= fault_s3;
		end
		if (adv[4]) begin
			sum_s5   <= q_s4 + ($signed(c9p_s4) >>> 25) + c8_s4;
			fault_s5 <= fault_s4;
		end
		if (adv[5]) begin
			press_s6 <= sum_s5[39:8] + {{12{coef.p7[15]}}, coef.p7, 4'd0};
			fault_s6 <= fault_s5;
		end
	end

endmodule
